>>> sv/salu_pkg.sv
// Shared types and codes for the stack ALU with divide.
package salu_pkg;

    localparam int WORD_W = 32;
    localparam int DIV_CW = $clog2(WORD_W);

    localparam logic [2:0] ACT_PUSH = 3'd0;
    localparam logic [2:0] ACT_POP  = 3'd1;
    localparam logic [2:0] ACT_ADD  = 3'd2;
    localparam logic [2:0] ACT_SUB  = 3'd3;
    localparam logic [2:0] ACT_MUL  = 3'd4;
    localparam logic [2:0] ACT_DIV  = 3'd5;
    localparam logic [2:0] ACT_REM  = 3'd6;
    localparam logic [2:0] ACT_PEEK = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_UNDER = 2'd2;
    localparam logic [1:0] ST_DIVZ  = 2'd3;

    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] dividend;
        logic [WORD_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [WORD_W-1:0] quotient;
        logic [WORD_W-1:0] remainder;
    } t_div_rsp;

endpackage

>>> sv/salu_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module salu_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/salu_div.sv
// Radix-2 restoring divider for unsigned 32-bit magnitudes, one quotient bit per cycle.
module salu_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  salu_pkg::t_div_req i_req,
    output salu_pkg::t_div_rsp o_rsp
);

    import salu_pkg::*;

    logic [WORD_W-1:0] r_rem;
    logic [WORD_W-1:0] r_quo;
    logic [WORD_W-1:0] r_den;
    logic [DIV_CW-1:0] r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [WORD_W:0]   w_shift;
    logic [WORD_W:0]   w_diff;

    // Bring down the next dividend bit and try to subtract the divisor.
    assign w_shift = {r_rem, r_quo[WORD_W-1]};
    assign w_diff  = w_shift - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == {DIV_CW{1'b1}}) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            if (!w_diff[WORD_W]) begin
                r_rem <= w_diff[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], 1'b1};
            end else begin
                r_rem <= w_shift[WORD_W-1:0];
                r_quo <= {r_quo[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign o_rsp.done      = r_done;
    assign o_rsp.quotient  = r_quo;
    assign o_rsp.remainder = r_rem;

endmodule

>>> sv/stack_alu_with_divide.sv
// Top level: operand stack, command sequencer and result register.
//
// Usage: one command word enters on the input channel (i_valid, o_stall,
// i_action, i_push_value) and exactly one result word leaves on the output
// channel (o_valid, i_stall, o_status, o_top_value, o_fill_level).
// The block works on one command at a time and raises o_stall from the
// cycle after acceptance until the command has been committed.
// Push, pop, peek, add, subtract, multiply and every command that ends in an
// error pass through the fetch, execute and finish steps. Divide and
// remainder also wait in a divide step between execute and finish while the
// shared radix-2 divider runs for 32 iterations.
// The stack lives in a small RAM with a registered read port; the top entry
// is also held in a register so that it can be reported at once.
// Reset empties the stack and drops any pending result word.
// While the receiver stalls, the result word is held; a new command may still
// be accepted, but it waits in its last step until the result register frees.
module stack_alu_with_divide #(
    parameter int STACK_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_action,
    input  logic [31:0] i_push_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_status,
    output logic [31:0] o_top_value,
    output logic [3:0]  o_fill_level
);

    import salu_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_FETCH = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_DIV   = 3'd3;
    localparam logic [2:0] S_FIN   = 3'd4;

    localparam logic [CW-1:0] DEPTH_C = CW'(STACK_DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);
    localparam logic [CW-1:0] TWO_C   = CW'(2);

    logic [2:0]        r_state, n_state;
    logic [CW-1:0]     r_count, n_count;
    logic [WORD_W-1:0] r_top, n_top;
    logic [2:0]        r_act;
    logic [WORD_W-1:0] r_val;
    logic [WORD_W-1:0] r_b;
    logic [WORD_W-1:0] r_res, n_res;
    logic [1:0]        r_status, n_status;
    logic              r_neg, n_neg;
    logic              r_use_rem, n_use_rem;
    logic              r_ovalid;
    logic [1:0]        r_ostatus;
    logic [WORD_W-1:0] r_otop;
    logic [3:0]        r_ofill;

    logic              w_we;
    logic [AW-1:0]     w_waddr;
    logic [WORD_W-1:0] w_wdata;
    logic [AW-1:0]     w_raddr;
    logic [WORD_W-1:0] w_rdata;
    logic [CW-1:0]     w_below;
    logic              w_accept;
    logic              w_commit;
    logic [WORD_W-1:0] w_prod;
    logic [WORD_W-1:0] w_mag_a, w_mag_b;
    logic              w_a_ge_b;
    logic [WORD_W-1:0] w_num, w_den;
    logic [WORD_W-1:0] w_dres;
    logic [CW+3:0]     w_fill_ext;

    t_div_req w_req;
    t_div_rsp w_rsp;

    assign w_accept = i_valid && !o_stall;
    assign w_commit = (r_state == S_FIN) && (!r_ovalid || !i_stall);
    assign w_below  = r_count - TWO_C;
    assign w_raddr  = w_below[AW-1:0];

    salu_ram #(
        .WIDTH(WORD_W),
        .DEPTH(STACK_DEPTH)
    ) u_store (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    salu_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    // Operand a is the cached top entry, operand b the entry just below it.
    assign w_prod   = r_top * r_b;
    assign w_mag_a  = r_top[WORD_W-1] ? (~r_top + 1'b1) : r_top;
    assign w_mag_b  = r_b[WORD_W-1] ? (~r_b + 1'b1) : r_b;
    assign w_a_ge_b = $signed(r_top) >= $signed(r_b);
    assign w_num    = (r_act == ACT_REM || w_a_ge_b) ? r_top : r_b;
    assign w_den    = (r_act == ACT_REM || w_a_ge_b) ? r_b : r_top;

    always_comb begin
        w_req.start    = 1'b0;
        w_req.dividend = (r_act == ACT_REM || w_a_ge_b) ? w_mag_a : w_mag_b;
        w_req.divisor  = (r_act == ACT_REM || w_a_ge_b) ? w_mag_b : w_mag_a;
        if (r_state == S_EXEC && r_count >= TWO_C && w_den != '0 &&
            (r_act == ACT_DIV || r_act == ACT_REM)) begin
            w_req.start = 1'b1;
        end
    end

    always_comb begin
        w_dres = r_use_rem ? w_rsp.remainder : w_rsp.quotient;
        if (r_neg) begin
            w_dres = ~w_dres + 1'b1;
        end
    end

    // Sequencer.
    always_comb begin
        n_state   = r_state;
        n_res     = r_res;
        n_status  = r_status;
        n_neg     = r_neg;
        n_use_rem = r_use_rem;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state  = S_FIN;
                n_status = ST_OK;
                unique case (r_act)
                    ACT_PUSH: begin
                        if (r_count >= DEPTH_C) begin
                            n_status = ST_FULL;
                        end
                    end
                    ACT_POP, ACT_PEEK: begin
                        if (r_count == '0) begin
                            n_status = ST_UNDER;
                        end
                    end
                    default: begin
                        if (r_count < TWO_C) begin
                            n_status = ST_UNDER;
                        end else begin
                            unique case (r_act)
                                ACT_ADD: n_res = r_top + r_b;
                                ACT_SUB: n_res = r_top - r_b;
                                ACT_MUL: n_res = w_prod;
                                default: begin
                                    n_use_rem = (r_act == ACT_REM);
                                    n_neg     = (r_act == ACT_REM) ? r_top[WORD_W-1]
                                                                   : (w_num[WORD_W-1] ^
                                                                      w_den[WORD_W-1]);
                                    if (w_den == '0) begin
                                        n_status = ST_DIVZ;
                                    end else begin
                                        n_state = S_DIV;
                                    end
                                end
                            endcase
                        end
                    end
                endcase
            end
            S_DIV: begin
                if (w_rsp.done) begin
                    n_res   = w_dres;
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_commit) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Stack update at commit.
    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        w_we    = 1'b0;
        w_waddr = r_count[AW-1:0];
        w_wdata = r_val;
        if (w_commit && r_status == ST_OK) begin
            unique case (r_act)
                ACT_PUSH: begin
                    w_we    = 1'b1;
                    n_top   = r_val;
                    n_count = r_count + ONE_C;
                end
                ACT_POP: begin
                    n_count = r_count - ONE_C;
                    n_top   = (r_count >= TWO_C) ? r_b : '0;
                end
                ACT_PEEK: begin
                    n_count = r_count;
                end
                default: begin
                    w_we    = 1'b1;
                    w_waddr = w_below[AW-1:0];
                    w_wdata = r_res;
                    n_top   = r_res;
                    n_count = r_count - ONE_C;
                end
            endcase
        end
    end

    assign w_fill_ext = {4'b0000, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_top    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_top   <= n_top;
            if (w_commit) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_act <= i_action;
            r_val <= i_push_value;
        end
        if (r_state == S_FETCH) begin
            r_b <= w_rdata;
        end
        r_res     <= n_res;
        r_status  <= n_status;
        r_neg     <= n_neg;
        r_use_rem <= n_use_rem;
        if (w_commit) begin
            r_ostatus <= r_status;
            r_otop    <= n_top;
            r_ofill   <= w_fill_ext[3:0];
        end
    end

    assign o_stall      = (r_state != S_IDLE);
    assign o_valid      = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_top_value  = r_otop;
    assign o_fill_level = r_ofill;

endmodule

>>> verif/stack_alu_with_divide_test.sv
// Self-checking testbench for the stack ALU with divide: directed table, then random commands.
`timescale 1ns / 1ps

module stack_alu_with_divide_test;
    import salu_pkg::*;

    localparam int DEPTH = 8;
    localparam int RANDOM_WORDS = 1925;
    localparam int IDLE_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] top;
        logic [3:0]  fill;
    } t_stack_view;

    typedef struct packed {
        logic [2:0]  act;
        logic [31:0] word;
        logic        known;
        t_stack_view view;
    } t_directed_row;

    // Rows with known set carry a result that is plain from the stack contents.
    localparam t_directed_row DIRECTED [25] = '{
        '{ACT_POP,  32'h0000_0000, 1'b1, '{ST_UNDER, 32'h0000_0000, 4'd0}},
        '{ACT_PEEK, 32'h0000_0000, 1'b1, '{ST_UNDER, 32'h0000_0000, 4'd0}},
        '{ACT_MUL,  32'h0000_0000, 1'b1, '{ST_UNDER, 32'h0000_0000, 4'd0}},
        '{ACT_PUSH, 32'h7fff_ffff, 1'b1, '{ST_OK,    32'h7fff_ffff, 4'd1}},
        '{ACT_SUB,  32'h0000_0000, 1'b1, '{ST_UNDER, 32'h7fff_ffff, 4'd1}},
        '{ACT_PUSH, 32'h8000_0000, 1'b1, '{ST_OK,    32'h8000_0000, 4'd2}},
        '{ACT_ADD,  32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 4'd0}},
        '{ACT_PUSH, 32'hffff_ffff, 1'b1, '{ST_OK,    32'hffff_ffff, 4'd2}},
        '{ACT_PUSH, 32'h8000_0000, 1'b1, '{ST_OK,    32'h8000_0000, 4'd3}},
        '{ACT_REM,  32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 4'd0}},
        '{ACT_PUSH, 32'h0000_0007, 1'b1, '{ST_OK,    32'h0000_0007, 4'd3}},
        '{ACT_REM,  32'h0000_0000, 1'b1, '{ST_DIVZ,  32'h0000_0007, 4'd3}},
        '{ACT_POP,  32'h0000_0000, 1'b1, '{ST_OK,    32'h0000_0000, 4'd2}},
        '{ACT_PUSH, 32'h0000_0009, 1'b1, '{ST_OK,    32'h0000_0009, 4'd3}},
        '{ACT_DIV,  32'h0000_0000, 1'b1, '{ST_DIVZ,  32'h0000_0009, 4'd3}},
        '{ACT_MUL,  32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 4'd0}},
        '{ACT_PUSH, 32'h7fff_ffff, 1'b1, '{ST_OK,    32'h7fff_ffff, 4'd3}},
        '{ACT_PUSH, 32'h8000_0000, 1'b1, '{ST_OK,    32'h8000_0000, 4'd4}},
        '{ACT_PUSH, 32'haaaa_aaaa, 1'b1, '{ST_OK,    32'haaaa_aaaa, 4'd5}},
        '{ACT_PUSH, 32'h5555_5555, 1'b1, '{ST_OK,    32'h5555_5555, 4'd6}},
        '{ACT_PUSH, 32'h0000_0001, 1'b1, '{ST_OK,    32'h0000_0001, 4'd7}},
        '{ACT_PUSH, 32'hffff_fffd, 1'b1, '{ST_OK,    32'hffff_fffd, 4'd8}},
        '{ACT_PUSH, 32'h1234_5678, 1'b1, '{ST_FULL,  32'hffff_fffd, 4'd8}},
        '{ACT_SUB,  32'h0000_0000, 1'b0, '{ST_OK,    32'h0000_0000, 4'd0}},
        '{ACT_DIV,  32'hffff_ffff, 1'b0, '{ST_OK,    32'h0000_0000, 4'd0}}
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [2:0]  i_action;
    logic [31:0] i_push_value;
    logic        o_valid;
    logic        i_stall;
    logic [1:0]  o_status;
    logic [31:0] o_top_value;
    logic [3:0]  o_fill_level;

    logic [31:0] model_stack [DEPTH];
    int          model_count;
    t_stack_view expected_views [$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned words_sent;
    int unsigned idle_cycles;

    stack_alu_with_divide #(
        .STACK_DEPTH(DEPTH)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_action(i_action),
        .i_push_value(i_push_value),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_status(o_status),
        .o_top_value(o_top_value),
        .o_fill_level(o_fill_level)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string what);
        if (mismatches < 40) begin
            $display("MISMATCH at %0t: %s", $time, what);
        end
        mismatches++;
    endtask

    // Applies one command to the model stack and returns the view it leaves.
    function automatic t_stack_view apply_command(input logic [2:0] act, input logic [31:0] word);
        t_stack_view view;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] num;
        logic [31:0] den;
        logic [31:0] mag_num;
        logic [31:0] mag_den;
        logic [31:0] res;
        view.status = ST_OK;
        res = '0;
        if (act == ACT_PUSH) begin
            if (model_count >= DEPTH) begin
                view.status = ST_FULL;
            end else begin
                model_stack[model_count] = word;
                model_count++;
            end
        end else if (act == ACT_POP || act == ACT_PEEK) begin
            if (model_count == 0) begin
                view.status = ST_UNDER;
            end else if (act == ACT_POP) begin
                model_count--;
            end
        end else if (model_count < 2) begin
            view.status = ST_UNDER;
        end else begin
            a = model_stack[model_count - 1];
            b = model_stack[model_count - 2];
            case (act)
                ACT_ADD: res = a + b;
                ACT_SUB: res = a - b;
                ACT_MUL: res = a * b;
                ACT_DIV: begin
                    // The larger operand is always the dividend.
                    num = ($signed(a) >= $signed(b)) ? a : b;
                    den = ($signed(a) >= $signed(b)) ? b : a;
                    if (den == '0) begin
                        view.status = ST_DIVZ;
                    end else begin
                        mag_num = num[31] ? -num : num;
                        mag_den = den[31] ? -den : den;
                        res = mag_num / mag_den;
                        if (num[31] ^ den[31]) begin
                            res = -res;
                        end
                    end
                end
                ACT_REM: begin
                    if (b == '0) begin
                        view.status = ST_DIVZ;
                    end else begin
                        mag_num = a[31] ? -a : a;
                        mag_den = b[31] ? -b : b;
                        res = mag_num % mag_den;
                        if (a[31]) begin
                            res = -res;
                        end
                    end
                end
                default: ;
            endcase
            if (view.status == ST_OK) begin
                model_count--;
                model_stack[model_count - 1] = res;
            end
        end
        view.top = (model_count != 0) ? model_stack[model_count - 1] : '0;
        view.fill = 4'(model_count);
        return view;
    endfunction

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_command(input logic [2:0] act, input logic [31:0] word,
                                input logic known, input t_stack_view known_view);
        t_stack_view predicted;
        while (!(words_sent >= 600 && words_sent < 900) && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_push_value <= word;
        do @(posedge i_clk); while (o_stall);
        predicted = apply_command(act, word);
        expected_views.push_back(known ? known_view : predicted);
        words_sent++;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic [2:0]  act;
        logic [31:0] word;
        int          push_pct;
        mismatches = 0;
        results_seen = 0;
        words_sent = 0;
        model_count = 0;
        foreach (model_stack[k]) model_stack[k] = '0;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_action = ACT_PUSH;
        i_push_value = '0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < 25; r++) begin
            send_command(DIRECTED[r].act, DIRECTED[r].word, DIRECTED[r].known,
                         DIRECTED[r].view);
        end

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            // Alternate filling and draining stretches so the stack swings from
            // empty to full many times.
            push_pct = ((n / 48) % 2 == 0) ? 60 : 25;
            if ($urandom_range(99) < push_pct) begin
                act = ACT_PUSH;
            end else begin
                act = 3'($urandom_range(7, 1));
            end
            case ($urandom_range(15))
                0, 1, 2, 3: word = 32'($signed($urandom_range(18)) - 9);
                4: word = 32'h8000_0000;
                5: word = 32'h7fff_ffff;
                6: word = ($urandom_range(1) != 0) ? 32'hffff_ffff : 32'h0000_0000;
                default: word = $urandom;
            endcase
            if (words_sent == 1200) begin
                // Let the block empty out completely before going on.
                i_valid <= 1'b0;
                wait (expected_views.size() == 0);
                @(negedge i_clk);
            end
            send_command(act, word, 1'b0, '0);
        end
        i_valid <= 1'b0;

        wait (expected_views.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin : receiver
        bit held;
        held = 1'b0;
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!held && results_seen >= 300) begin
                // Long hold-off: the sender keeps offering and the block backs up.
                held = 1'b1;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            if (results_seen >= 600 && results_seen < 900) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= ($urandom_range(99) < 16);
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_stack_view want;
        if (i_rst_n && o_valid && !i_stall) begin
            results_seen++;
            if (expected_views.size() == 0) begin
                report_mismatch($sformatf("unexpected word status=%0d top=%h fill=%0d",
                                          o_status, o_top_value, o_fill_level));
            end else begin
                want = expected_views.pop_front();
                if (o_status !== want.status) begin
                    report_mismatch($sformatf("status got %0d want %0d",
                                              o_status, want.status));
                end
                if (o_top_value !== want.top) begin
                    report_mismatch($sformatf("top_value got %h want %h",
                                              o_top_value, want.top));
                end
                if (o_fill_level !== want.fill) begin
                    report_mismatch($sformatf("fill_level got %0d want %0d",
                                              o_fill_level, want.fill));
                end
            end
        end
    end

    always @(posedge i_clk) begin : watchdog
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

>>> files.f
sv/salu_pkg.sv
sv/salu_ram.sv
sv/salu_div.sv
sv/stack_alu_with_divide.sv
verif/stack_alu_with_divide_test.sv
